// ===== hdl/hts_pkg.sv =====
// Shared types and constants of the two-dimensional histogram store.
// Used by every module of the block but hts_ram; depends on nothing.
package hts_pkg;

  localparam int NumSpectra       = 4;
  localparam int CellsPerSpectrum = 4096;
  localparam int CountWidth       = 32;
  localparam int TotalCells       = NumSpectra * CellsPerSpectrum;
  localparam int AddrWidth        = $clog2(TotalCells);
  localparam int CellIdxWidth     = $clog2(CellsPerSpectrum);

  localparam int RegWidth     = 13;
  localparam int CoordWidth   = 13;
  localparam int OperandWidth = 32;
  localparam int ValueWidth   = 32;
  localparam int KindWidth    = 2;
  localparam int SpecWidth    = 2;
  localparam int CfgIdxWidth  = 4;

  localparam int ProdWidth = (CoordWidth - 1) + RegWidth;
  localparam int SumWidth  = ProdWidth + 1;

  localparam int QueueDepth = 2;

  localparam logic [RegWidth-1:0] RegReset = RegWidth'(64);

  localparam logic [KindWidth-1:0] KindAdd   = 2'd0;
  localparam logic [KindWidth-1:0] KindRead  = 2'd1;
  localparam logic [KindWidth-1:0] KindWrite = 2'd2;

  typedef struct packed {
    logic [KindWidth-1:0]    kind;
    logic                    ok;
    logic [AddrWidth-1:0]    addr;
    logic [OperandWidth-1:0] operand;
  } hts_op_t;

endpackage

// ===== hdl/hts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hts_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hts_front.sv =====
// Front part: geometry registers, range checks and cell address of each item.
// Depends on hts_pkg.
module hts_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [hts_pkg::CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [hts_pkg::RegWidth-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [hts_pkg::KindWidth-1:0]          kind_i,
  input  logic [hts_pkg::SpecWidth-1:0]          spectrum_i,
  input  logic signed [hts_pkg::CoordWidth-1:0]  x_coord_i,
  input  logic signed [hts_pkg::CoordWidth-1:0]  y_coord_i,
  input  logic signed [hts_pkg::OperandWidth-1:0] operand_i,
  input  logic                                   clear_done_i,
  input  logic                                   q_ready_i,
  output logic                                   q_push_o,
  output hts_pkg::hts_op_t                       q_op_o
);
  import hts_pkg::*;

  logic [RegWidth-1:0] cols_q [NumSpectra];
  logic [RegWidth-1:0] rows_q [NumSpectra];

  logic [RegWidth-1:0]   cols;
  logic [RegWidth-1:0]   rows;
  logic                  x_ok;
  logic                  y_ok;
  logic                  spec_ok;
  logic                  kind_ok;
  logic [ProdWidth-1:0]  prod;
  logic [SumWidth-1:0]   cell_idx;
  logic                  idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSpectra; k++) begin
        cols_q[k] <= RegReset;
        rows_q[k] <= RegReset;
      end
    end else if (cfg_valid_i) begin
      for (int k = 0; k < NumSpectra; k++) begin
        if (cfg_index_i == CfgIdxWidth'(2 * k)) begin
          cols_q[k] <= cfg_data_i;
        end
        if (cfg_index_i == CfgIdxWidth'(2 * k + 1)) begin
          rows_q[k] <= cfg_data_i;
        end
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  assign cols = cols_q[spectrum_i];
  assign rows = rows_q[spectrum_i];

  assign x_ok = !x_coord_i[CoordWidth-1] &&
                (RegWidth'(x_coord_i[CoordWidth-2:0]) < cols);
  assign y_ok = !y_coord_i[CoordWidth-1] &&
                (RegWidth'(y_coord_i[CoordWidth-2:0]) < rows);
  assign spec_ok = ({1'b0, spectrum_i} < (SpecWidth + 1)'(NumSpectra));
  assign kind_ok = kind_i inside {KindAdd, KindRead, KindWrite};

  assign prod     = ProdWidth'(y_coord_i[CoordWidth-2:0]) * ProdWidth'(cols);
  assign cell_idx = SumWidth'(prod) + SumWidth'(x_coord_i[CoordWidth-2:0]);
  assign idx_ok   = cell_idx < SumWidth'(CellsPerSpectrum);

  assign in_ready_o = q_ready_i && clear_done_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_op_o.kind    = kind_i;
    q_op_o.ok      = kind_ok && spec_ok && x_ok && y_ok && idx_ok;
    q_op_o.addr    = (AddrWidth'(spectrum_i) << CellIdxWidth) |
                     AddrWidth'(cell_idx[CellIdxWidth-1:0]);
    q_op_o.operand = operand_i;
  end

endmodule

// ===== hdl/hts_queue.sv =====
// Short queue of classified operations between the front and back parts.
// Depends on hts_pkg.
module hts_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hts_pkg::hts_op_t op_i,
  output logic             ready_o,
  output logic             valid_o,
  output hts_pkg::hts_op_t op_o,
  input  logic             pop_i
);
  import hts_pkg::*;

  localparam int PtrWidth = $clog2(QueueDepth);

  hts_op_t               entry_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q;
  logic [PtrWidth-1:0]   rd_ptr_q;
  logic [PtrWidth:0]     cnt_q;

  function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
    return (p == PtrWidth'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = cnt_q != (PtrWidth + 1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign op_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/hts_back.sv =====
// Back part: clearing pass, read-modify-write on the count RAM, result register.
// Depends on hts_pkg and hts_ram.
module hts_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  hts_pkg::hts_op_t                      q_op_i,
  output logic                                  q_pop_o,
  output logic                                  clear_done_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hts_pkg::ValueWidth-1:0] read_value_o,
  output logic                                  in_range_o
);
  import hts_pkg::*;

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StAccess = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [AddrWidth-1:0]  clr_q;
  hts_op_t               cur_q;
  logic                  out_valid_q;
  logic [ValueWidth-1:0] value_q, value_d;
  logic                  range_q, range_d;
  logic                  load_out;
  logic                  slot_free;

  logic                  ram_we;
  logic [AddrWidth-1:0]  ram_waddr;
  logic [CountWidth-1:0] ram_wdata;
  logic [CountWidth-1:0] ram_rdata;
  logic [CountWidth-1:0] operand_ext;
  logic [CountWidth-1:0] add_res;

  hts_ram #(
    .Width (CountWidth),
    .Depth (TotalCells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (q_op_i.addr),
    .rdata_o (ram_rdata)
  );

  assign slot_free    = !out_valid_q || out_ready_i;
  assign q_pop_o      = (state_q == StIdle) && q_valid_i && slot_free;
  assign clear_done_o = state_q != StClear;
  assign operand_ext  = CountWidth'(signed'(cur_q.operand));
  assign add_res      = ram_rdata + operand_ext;

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q.addr;
    ram_wdata = operand_ext;
    load_out  = 1'b0;
    value_d   = '0;
    range_d   = 1'b0;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AddrWidth'(TotalCells - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (q_pop_o) begin
          if (q_op_i.ok) begin
            state_d = StAccess;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      StAccess: begin
        ram_we    = cur_q.kind != KindRead;
        ram_wdata = (cur_q.kind == KindAdd) ? add_res : operand_ext;
        load_out  = 1'b1;
        range_d   = 1'b1;
        value_d   = (cur_q.kind == KindRead) ? ValueWidth'(signed'(ram_rdata)) : '0;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_op_i;
    end
    if (load_out) begin
      value_q <= value_d;
      range_q <= range_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = value_q;
  assign in_range_o   = range_q;

endmodule

// ===== hdl/two_d_histogram_store.sv =====
// Two-dimensional histogram store: four spectra of 4096 32-bit counts in one RAM.
// An in-range item passes from the queue through the access state to the result register, a
// rejected one straight to it. The next in-range item waits out the read-modify-write on the
// RAM port; rejected items pass at one per cycle while results are taken. A 2-entry queue
// decouples input from the RAM. Reset: geometry registers return to 64; a clearing pass zeroes
// all 16384 RAM cells, with in_ready_o low throughout; configuration writes are taken during it.
module two_d_histogram_store (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [hts_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [hts_pkg::RegWidth-1:0]            cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [hts_pkg::KindWidth-1:0]           kind_i,
  input  logic [hts_pkg::SpecWidth-1:0]           spectrum_i,
  input  logic signed [hts_pkg::CoordWidth-1:0]   x_coord_i,
  input  logic signed [hts_pkg::CoordWidth-1:0]   y_coord_i,
  input  logic signed [hts_pkg::OperandWidth-1:0] operand_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [hts_pkg::ValueWidth-1:0]   read_value_o,
  output logic                                    in_range_o
);
  import hts_pkg::*;

  logic    clear_done;
  logic    push;
  logic    q_ready;
  logic    q_valid;
  logic    q_pop;
  hts_op_t push_op;
  hts_op_t head_op;

  hts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .spectrum_i   (spectrum_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .operand_i    (operand_i),
    .clear_done_i (clear_done),
    .q_ready_i    (q_ready),
    .q_push_o     (push),
    .q_op_o       (push_op)
  );

  hts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .op_o    (head_op),
    .pop_i   (q_pop)
  );

  hts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_op_i       (head_op),
    .q_pop_o      (q_pop),
    .clear_done_o (clear_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .in_range_o   (in_range_o)
  );

endmodule

// ===== hdl/hts_checker.sv =====
// Port-level checks of the histogram store, bound to the top level.
// Depends on hts_pkg and two_d_histogram_store.
module hts_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [hts_pkg::ValueWidth-1:0] read_value_o,
  input logic                                  in_range_o
);
  import hts_pkg::*;

  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> read_value_o == '0)
    else $error("rejected transaction carries a nonzero value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) && $stable(in_range_o))
    else $error("stalled result changed");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input taken before clearing pass");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without an outstanding transaction");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("too many outstanding transactions");

endmodule

bind two_d_histogram_store hts_checker u_hts_checker (.*);
